### design/fmpd_pkg.sv
package fmpd_pkg;

  // arctangent step count, capped at the table length
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN    = 24;
  localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                     CORDIC_ITERATIONS : ATAN_TABLE_LEN;

  // datapath widths
  localparam int SAMPLE_W = 9;   // recentred component, -255..255
  localparam int PROD_W   = 18;  // one component product
  localparam int SUM_W    = 19;  // re or im of conj(prev)*curr
  localparam int FRAC_W   = 16;  // scaling applied before the cordic
  localparam int XY_W     = 37;  // cordic x and y with gain headroom
  localparam int ANG_W    = 34;  // angle in units of pi/2^31
  localparam int OUT_W    = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [XY_W-1:0]     xy_t;
  typedef logic signed [ANG_W-1:0]    ang_t;

  // results that bypass the cordic
  typedef enum logic [2:0] {
    SPC_CORDIC,
    SPC_ZERO,
    SPC_PI,
    SPC_POS_HALF,
    SPC_NEG_HALF
  } special_e;

  typedef struct packed {
    xy_t      x;
    xy_t      y;
    ang_t     z;
    special_e special;
    logic     eob;
  } cordic_t;

  // round(atan(2^-k)/pi * 2^31)
  function automatic ang_t atan_entry(input int k);
    ang_t val;
    case (k)
      0:       val = 34'sd536870912;
      1:       val = 34'sd316933406;
      2:       val = 34'sd167458907;
      3:       val = 34'sd85004756;
      4:       val = 34'sd42667331;
      5:       val = 34'sd21354465;
      6:       val = 34'sd10679838;
      7:       val = 34'sd5340245;
      8:       val = 34'sd2670163;
      9:       val = 34'sd1335087;
      10:      val = 34'sd667544;
      11:      val = 34'sd333772;
      12:      val = 34'sd166886;
      13:      val = 34'sd83443;
      14:      val = 34'sd41722;
      15:      val = 34'sd20861;
      16:      val = 34'sd10430;
      17:      val = 34'sd5215;
      18:      val = 34'sd2608;
      19:      val = 34'sd1304;
      20:      val = 34'sd652;
      21:      val = 34'sd326;
      22:      val = 34'sd163;
      23:      val = 34'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### design/fmpd_cordic.sv
module fmpd_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              valid_i,
  input  fmpd_pkg::cordic_t data_i,
  output logic              valid_o,
  output fmpd_pkg::cordic_t data_o
);
  import fmpd_pkg::*;

  cordic_t                  stg_q [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_q;

  // one vectoring rotation per register stage
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    cordic_t in_w;
    cordic_t nxt_w;
    logic    in_vld_w;
    xy_t     x_w;
    xy_t     y_w;

    if (k == 0) begin : g_first
      assign in_w     = data_i;
      assign in_vld_w = valid_i;
    end else begin : g_rest
      assign in_w     = stg_q[k-1];
      assign in_vld_w = vld_q[k-1];
    end

    // rotate toward the positive real axis, arithmetic shifts on old x and y
    always_comb begin
      nxt_w = in_w;
      x_w   = in_w.x;
      y_w   = in_w.y;
      if (!y_w[XY_W-1]) begin
        nxt_w.x = x_w + (y_w >>> k);
        nxt_w.y = y_w - (x_w >>> k);
        nxt_w.z = in_w.z + atan_entry(k);
      end else begin
        nxt_w.x = x_w - (y_w >>> k);
        nxt_w.y = y_w + (x_w >>> k);
        nxt_w.z = in_w.z - atan_entry(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (advance_i) begin
        vld_q[k] <= in_vld_w;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        stg_q[k] <= nxt_w;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign data_o  = stg_q[CORDIC_STAGES-1];

endmodule

### design/fm_polar_discriminator.sv
// FM polar discriminator: each transaction carries one unsigned 8-bit IQ pair, recentred to
// 2*x-255, and yields atan2 of conj(previous pair) * current pair divided by pi as signed
// Q1.15 (+1.0 saturates to 32767, a zero product gives 0), with the end-of-block flag copied
// alongside. The previous pair starts at (+255, 0) after reset. The block takes one
// transaction per clock while not stalled and returns exactly one result per transaction,
// passing through 5 + CORDIC_STAGES registers: an input register loaded at the accepting
// edge, a multiply stage, a sum stage, a quadrant/special-case stage, one register per
// cordic iteration and the output register. The arctangent pipeline sets this depth. A
// stall on the output while a result is held freezes the whole pipeline and is passed
// back to the input in the same cycle.
module fm_polar_discriminator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [7:0]                    i_sample_i,
  input  logic [7:0]                    q_sample_i,
  input  logic                          end_of_block_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [fmpd_pkg::OUT_W-1:0] freq_deviation_o,
  output logic                          end_of_block_out_o
);
  import fmpd_pkg::*;

  logic    advance;
  logic    accept;
  sample_t ci_w;
  sample_t cq_w;

  // previous pair
  sample_t prev_i_q;
  sample_t prev_q_q;

  // stage 1: input register
  logic    s1_vld_q;
  sample_t s1_ci_q, s1_cq_q, s1_pi_q, s1_pq_q;
  logic    s1_eob_q;

  // stage 2: products
  logic  s2_vld_q;
  prod_t s2_ii_q, s2_qq_q, s2_iq_q, s2_qi_q;
  logic  s2_eob_q;

  // stage 3: re and im
  logic s3_vld_q;
  sum_t s3_re_q, s3_im_q;
  logic s3_eob_q;

  // stage 4: cordic entry
  logic    s4_vld_q;
  cordic_t s4_q;
  cordic_t s4_d;
  sum_t    rot_x_w, rot_y_w;

  logic    cor_vld_w;
  cordic_t cor_data_w;

  ang_t                      round_w;
  logic signed [ANG_W-17:0]  quot_w;
  logic signed [OUT_W-1:0]   dev_w;

  // pipeline moves unless a finished result is held
  assign advance = !(valid_o && stall_i);
  assign stall_o = !advance;
  assign accept  = valid_i && advance;

  // recentre: 2*x+1-256 flips the top bit
  assign ci_w = {~i_sample_i[7], i_sample_i[6:0], 1'b1};
  assign cq_w = {~q_sample_i[7], q_sample_i[6:0], 1'b1};

  // valid bits and previous pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_i_q <= sample_t'(255);
      prev_q_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      if (accept) begin
        prev_i_q <= ci_w;
        prev_q_q <= cq_w;
      end
      if (advance) begin
        s1_vld_q <= valid_i;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
        s4_vld_q <= s3_vld_q;
        valid_o  <= cor_vld_w;
      end
    end
  end

  // quadrant fold and special cases
  always_comb begin
    s4_d     = '0;
    rot_x_w  = s3_re_q;
    rot_y_w  = s3_im_q;
    s4_d.z   = '0;
    if (s3_re_q[SUM_W-1]) begin
      if (!s3_im_q[SUM_W-1]) begin
        rot_x_w = s3_im_q;
        rot_y_w = -s3_re_q;
        s4_d.z  = ang_t'(1) <<< 30;
      end else begin
        rot_x_w = -s3_im_q;
        rot_y_w = s3_re_q;
        s4_d.z  = -(ang_t'(1) <<< 30);
      end
    end
    s4_d.x   = {{(XY_W-SUM_W-FRAC_W){rot_x_w[SUM_W-1]}}, rot_x_w, {FRAC_W{1'b0}}};
    s4_d.y   = {{(XY_W-SUM_W-FRAC_W){rot_y_w[SUM_W-1]}}, rot_y_w, {FRAC_W{1'b0}}};
    s4_d.eob = s3_eob_q;
    if (s3_im_q == '0) begin
      s4_d.special = s3_re_q[SUM_W-1] ? SPC_PI : SPC_ZERO;
    end else if (s3_re_q == '0) begin
      s4_d.special = s3_im_q[SUM_W-1] ? SPC_NEG_HALF : SPC_POS_HALF;
    end else begin
      s4_d.special = SPC_CORDIC;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ci_q  <= ci_w;
      s1_cq_q  <= cq_w;
      s1_pi_q  <= prev_i_q;
      s1_pq_q  <= prev_q_q;
      s1_eob_q <= end_of_block_i;

      s2_ii_q  <= s1_pi_q * s1_ci_q;
      s2_qq_q  <= s1_pq_q * s1_cq_q;
      s2_iq_q  <= s1_pi_q * s1_cq_q;
      s2_qi_q  <= s1_pq_q * s1_ci_q;
      s2_eob_q <= s1_eob_q;

      s3_re_q  <= SUM_W'(s2_ii_q) + SUM_W'(s2_qq_q);
      s3_im_q  <= SUM_W'(s2_iq_q) - SUM_W'(s2_qi_q);
      s3_eob_q <= s2_eob_q;

      s4_q     <= s4_d;

      freq_deviation_o   <= dev_w;
      end_of_block_out_o <= cor_data_w.eob;
    end
  end

  fmpd_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s4_vld_q),
    .data_i    (s4_q),
    .valid_o   (cor_vld_w),
    .data_o    (cor_data_w)
  );

  // round to Q1.15 and saturate
  assign round_w = cor_data_w.z + ang_t'(32768);
  assign quot_w  = round_w[ANG_W-1:FRAC_W];

  always_comb begin
    case (cor_data_w.special)
      SPC_ZERO:     dev_w = '0;
      SPC_PI:       dev_w = 16'sd32767;
      SPC_POS_HALF: dev_w = 16'sd16384;
      SPC_NEG_HALF: dev_w = -16'sd16384;
      SPC_CORDIC: begin
        if (quot_w > (ANG_W-FRAC_W)'(32767)) begin
          dev_w = 16'sd32767;
        end else if (quot_w < -(ANG_W-FRAC_W)'(32768)) begin
          dev_w = -16'sd32768;
        end else begin
          dev_w = quot_w[OUT_W-1:0];
        end
      end
      default:      dev_w = '0;
    endcase
  end

  // back-pressure only while a result is held
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held result");

  // an accepted pair becomes the previous pair
  a_prev_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (prev_i_q == $past(ci_w)) && (prev_q_q == $past(cq_w)))
    else $error("previous pair not updated on accept");

  // negative real axis saturates to +1.0
  a_pi_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cor_vld_w && (cor_data_w.special == SPC_PI)) |=>
    (valid_o && (freq_deviation_o == 16'sd32767)))
    else $error("negative real axis not saturated");

endmodule
